/* hw/rtl/rhca_pkg.sv */
// Shared types and constants for the RGB/HSL conversion and adjustment unit.
// Holds the beat structs for both channels and the front-to-back work item.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rhca_pkg;

	localparam int CHANNEL_BITS = 16;
	localparam int DIV_STEPS = CHANNEL_BITS + 1;
	localparam int DEN_W = CHANNEL_BITS + 3;
	localparam int NUM_W = 2 * CHANNEL_BITS + 3;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	localparam chan_t CH_FULL = '1;

	typedef enum logic [1:0] {
		OP_TO_HSL  = 2'd0,
		OP_TO_RGB  = 2'd1,
		OP_DARKEN  = 2'd2,
		OP_LIGHTEN = 2'd3
	} op_code_t;

	typedef struct packed {
		op_code_t operation;
		chan_t    red_or_hue;
		chan_t    green_or_sat;
		chan_t    blue_or_light;
		chan_t    alpha_in;
		chan_t    adjust_amount;
	} pixel_t;

	typedef struct packed {
		chan_t out_red_or_hue;
		chan_t out_green_or_sat;
		chan_t out_blue_or_light;
		chan_t alpha_out;
	} result_t;

	typedef struct packed {
		op_code_t               operation;
		chan_t                  chan_a;
		chan_t                  chan_b;
		chan_t                  chan_c;
		chan_t                  alpha;
		chan_t                  amount;
		logic                   grey;
		chan_t                  light;
		logic [NUM_W-1:0]       num_sat;
		logic [DEN_W-1:0]       den_sat;
		logic [NUM_W-1:0]       num_hue;
		logic [DEN_W-1:0]       den_hue;
	} work_t;

endpackage

/* hw/rtl/rhca_front.sv */
// Front end: takes pixel beats, finds maximum, minimum and lightness, and
// prepares the dividends and divisors for saturation and hue.
// Depends on rhca_pkg.
`timescale 1ns / 1ps

module rhca_front (
	input  logic            clk,
	input  logic            arst_n,
	input  rhca_pkg::pixel_t pixel,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	output rhca_pkg::work_t work,
	output logic            work_valid,
	input  logic            work_full
);
	import rhca_pkg::*;

	localparam int B = CHANNEL_BITS;

	chan_t          r, g, b, mx, mn, d;
	logic [B:0]     sum, den;
	logic [B+1:0]   sum_rnd;
	logic [B+2:0]   hue_num;
	logic [DEN_W-1:0] d6;
	work_t          nxt;
	logic           valid_s1;
	work_t          work_s1;

	always_comb begin
		r = pixel.red_or_hue;
		g = pixel.green_or_sat;
		b = pixel.blue_or_light;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		sum = {1'b0, mx} + {1'b0, mn};
		sum_rnd = {1'b0, sum} + (B+2)'(1);
		d = mx - mn;
		if (sum > {1'b0, CH_FULL}) begin
			den = {CH_FULL, 1'b0} - sum;
		end else begin
			den = sum;
		end
		d6 = DEN_W'({d, 2'b00}) + DEN_W'({d, 1'b0});
		priority if (mx == r) begin
			if (g >= b) begin
				hue_num = (B+3)'(g) - (B+3)'(b);
			end else begin
				hue_num = d6 - (B+3)'(b) + (B+3)'(g);
			end
		end else if (mx == g) begin
			hue_num = (B+3)'({d, 1'b0}) + (B+3)'(b) - (B+3)'(r);
		end else begin
			hue_num = (B+3)'({d, 2'b00}) + (B+3)'(r) - (B+3)'(g);
		end
		nxt.operation = pixel.operation;
		nxt.chan_a = r;
		nxt.chan_b = g;
		nxt.chan_c = b;
		nxt.alpha = pixel.alpha_in;
		nxt.amount = pixel.adjust_amount;
		nxt.grey = (mx == mn);
		nxt.light = sum_rnd[B:1];
		nxt.num_sat = NUM_W'({d, {B{1'b0}}}) - NUM_W'(d) + NUM_W'(den >> 1);
		nxt.den_sat = DEN_W'(den);
		nxt.num_hue = {hue_num, {B{1'b0}}} + NUM_W'({d, 1'b0}) + NUM_W'(d);
		nxt.den_hue = d6;
	end

	assign pixel_stall = valid_s1 & work_full;
	assign work_valid = valid_s1;
	assign work = work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pixel_stall) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pixel_stall && pixel_valid) begin
			work_s1 <= nxt;
		end
	end

endmodule

/* hw/rtl/rhca_queue.sv */
// Short queue of work items between the front end and the back end.
// Depends on rhca_pkg for the item type and the depth.
`timescale 1ns / 1ps

module rhca_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  rhca_pkg::work_t push_data,
	input  logic            push,
	output logic            full,
	output rhca_pkg::work_t head,
	input  logic            pop,
	output logic            empty
);
	import rhca_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	work_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign full = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + (PTR_W+1)'(1);
				2'b01: count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* hw/rtl/rhca_back.sv */
// Back end: pipelined restoring dividers for saturation and hue, lightness
// adjustment, and the HSL to RGB stages ending in the result register.
// Depends on rhca_pkg.
`timescale 1ns / 1ps

module rhca_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rhca_pkg::work_t   head,
	input  logic              empty,
	output logic              pop,
	output rhca_pkg::result_t result,
	output logic              result_valid,
	input  logic              result_stall
);
	import rhca_pkg::*;

	localparam int B = CHANNEL_BITS;
	localparam int LAST = DIV_STEPS - 1;
	localparam logic [B+2:0] TURN_1 = (B+3)'(2**B);
	localparam logic [B+2:0] TURN_3 = (B+3)'(3 * 2**B);
	localparam logic [B+2:0] TURN_4 = (B+3)'(4 * 2**B);
	localparam logic [B+3:0] TWO_TURN = (B+4)'(2 * 2**B);
	localparam logic [B+3:0] FOUR_TURN = (B+4)'(4 * 2**B);
	localparam logic [B+3:0] SIX_TURN = (B+4)'(6 * 2**B);

	typedef struct packed {
		logic [DEN_W-1:0]     rem_sat;
		logic [DIV_STEPS-1:0] quo_sat;
		logic [DEN_W-1:0]     rem_hue;
		logic [DIV_STEPS-1:0] quo_hue;
	} div_state_t;

	typedef struct packed {
		logic  pass;
		chan_t hue;
		chan_t sat;
		chan_t light;
		chan_t alpha;
	} hsl_item_t;

	typedef enum logic [1:0] {
		RAMP_UP,
		RAMP_HOLD_Q,
		RAMP_DOWN,
		RAMP_HOLD_P
	} ramp_t;

	typedef struct packed {
		ramp_t      sel;
		logic [B:0] frac;
	} ramp_pos_t;

	function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
			input logic nbit, input logic [DEN_W-1:0] den);
		logic [DEN_W:0] trial;
		trial = {rem, nbit};
		if (trial >= {1'b0, den}) begin
			return {1'b1, DEN_W'(trial - {1'b0, den})};
		end
		return {1'b0, trial[DEN_W-1:0]};
	endfunction

	function automatic logic [B+2:0] wrap_pos(input logic [B+3:0] pos);
		if (pos >= SIX_TURN) begin
			return (B+3)'(pos - SIX_TURN);
		end
		return pos[B+2:0];
	endfunction

	function automatic ramp_pos_t ramp_place(input logic [B+2:0] pos);
		ramp_pos_t rp;
		rp.frac = '0;
		if (pos < TURN_1) begin
			rp.sel = RAMP_UP;
			rp.frac = pos[B:0];
		end else if (pos < TURN_3) begin
			rp.sel = RAMP_HOLD_Q;
		end else if (pos < TURN_4) begin
			rp.sel = RAMP_DOWN;
			rp.frac = (B+1)'(TURN_4 - pos);
		end else begin
			rp.sel = RAMP_HOLD_P;
		end
		return rp;
	endfunction

	function automatic chan_t div_full(input logic [2*B:0] x);
		logic [2*B+1:0] y, z;
		y = (2*B+2)'(x) + (2*B+2)'(CH_FULL >> 1);
		z = y + (y >> B) + (2*B+2)'(1);
		return z[2*B-1:B];
	endfunction

	function automatic chan_t ramp_value(input chan_t p, input chan_t q,
			input ramp_t sel, input logic [2*B:0] prod);
		logic [2*B:0] acc;
		chan_t        res;
		acc = (2*B+1)'({p, {B{1'b0}}}) + prod + (2*B+1)'(2**(B-1));
		unique case (sel)
			RAMP_UP, RAMP_DOWN: res = acc[2*B-1:B];
			RAMP_HOLD_Q:        res = q;
			RAMP_HOLD_P:        res = p;
			default:            res = p;
		endcase
		return res;
	endfunction

	logic       adv;
	logic       dv_valid_s2 [DIV_STEPS];
	work_t      dv_item_s2 [DIV_STEPS];
	div_state_t dv_state_s2 [DIV_STEPS];

	assign adv = ~(result_valid & result_stall);
	assign pop = adv & ~empty;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		work_t          in_item;
		div_state_t     in_state;
		logic           in_valid;
		logic [DEN_W:0] step_sat, step_hue;
		div_state_t     nxt_state;

		if (k == 0) begin : g_first
			always_comb begin
				in_item = head;
				in_valid = ~empty;
				in_state.rem_sat = DEN_W'(head.num_sat >> DIV_STEPS);
				in_state.quo_sat = '0;
				in_state.rem_hue = DEN_W'(head.num_hue >> DIV_STEPS);
				in_state.quo_hue = '0;
			end
		end else begin : g_next
			always_comb begin
				in_item = dv_item_s2[k-1];
				in_valid = dv_valid_s2[k-1];
				in_state = dv_state_s2[k-1];
			end
		end

		always_comb begin
			step_sat = div_step(in_state.rem_sat, in_item.num_sat[DIV_STEPS-1-k],
				in_item.den_sat);
			step_hue = div_step(in_state.rem_hue, in_item.num_hue[DIV_STEPS-1-k],
				in_item.den_hue);
			nxt_state.rem_sat = step_sat[DEN_W-1:0];
			nxt_state.quo_sat = {in_state.quo_sat[DIV_STEPS-2:0], step_sat[DEN_W]};
			nxt_state.rem_hue = step_hue[DEN_W-1:0];
			nxt_state.quo_hue = {in_state.quo_hue[DIV_STEPS-2:0], step_hue[DEN_W]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s2[k] <= 1'b0;
			end else if (adv) begin
				dv_valid_s2[k] <= in_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_item_s2[k] <= in_item;
				dv_state_s2[k] <= nxt_state;
			end
		end
	end

	work_t      fin_item;
	div_state_t fin_state;
	logic [B:0] light_up;
	hsl_item_t  hs_nxt;

	always_comb begin
		fin_item = dv_item_s2[LAST];
		fin_state = dv_state_s2[LAST];
		light_up = {1'b0, fin_item.light} + {1'b0, fin_item.amount};
		hs_nxt.pass = 1'b0;
		hs_nxt.hue = fin_item.grey ? '0 : fin_state.quo_hue[B-1:0];
		hs_nxt.sat = fin_item.grey ? '0 : fin_state.quo_sat[B-1:0];
		hs_nxt.light = fin_item.light;
		hs_nxt.alpha = fin_item.alpha;
		unique case (fin_item.operation)
			OP_TO_HSL: hs_nxt.pass = 1'b1;
			OP_TO_RGB: begin
				hs_nxt.hue = fin_item.chan_a;
				hs_nxt.sat = fin_item.chan_b;
				hs_nxt.light = fin_item.chan_c;
			end
			OP_DARKEN: hs_nxt.light = (fin_item.light > fin_item.amount) ?
				fin_item.light - fin_item.amount : '0;
			OP_LIGHTEN: hs_nxt.light = (light_up > {1'b0, CH_FULL}) ?
				CH_FULL : light_up[B-1:0];
			default: hs_nxt.pass = 1'b0;
		endcase
	end

	logic           valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	hsl_item_t      hs_s3, hs_s4, hs_s5, hs_s6, hs_s7;
	logic [2*B-1:0] ls_s4;
	logic [2*B:0]   q2_s5, p2_s5;
	chan_t          q_s6, p_s6, q_s7, p_s7;
	ramp_pos_t      rp_r_s6, rp_g_s6, rp_b_s6;
	ramp_t          sel_r_s7, sel_g_s7, sel_b_s7;
	logic [2*B:0]   prod_r_s7, prod_g_s7, prod_b_s7;
	result_t        result_s8;

	logic [2*B-1:0] lm, sm;
	logic [2*B:0]   q2, p2;
	logic [B+3:0]   t6;
	chan_t          diff;
	result_t        res_nxt;

	always_comb begin
		lm = {hs_s4.light, {B{1'b0}}} - (2*B)'(hs_s4.light);
		sm = {hs_s4.sat, {B{1'b0}}} - (2*B)'(hs_s4.sat);
		if ({hs_s4.light, 1'b0} < {1'b0, CH_FULL}) begin
			q2 = (2*B+1)'(lm) + (2*B+1)'(ls_s4);
		end else begin
			q2 = (2*B+1)'(lm) + (2*B+1)'(sm) - (2*B+1)'(ls_s4);
		end
		p2 = {lm, 1'b0} - q2;
		t6 = (B+4)'({hs_s5.hue, 2'b00}) + (B+4)'({hs_s5.hue, 1'b0});
		diff = q_s6 - p_s6;
		res_nxt.alpha_out = hs_s7.alpha;
		if (hs_s7.pass) begin
			res_nxt.out_red_or_hue = hs_s7.hue;
			res_nxt.out_green_or_sat = hs_s7.sat;
			res_nxt.out_blue_or_light = hs_s7.light;
		end else begin
			res_nxt.out_red_or_hue = ramp_value(p_s7, q_s7, sel_r_s7, prod_r_s7);
			res_nxt.out_green_or_sat = ramp_value(p_s7, q_s7, sel_g_s7, prod_g_s7);
			res_nxt.out_blue_or_light = ramp_value(p_s7, q_s7, sel_b_s7, prod_b_s7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= dv_valid_s2[LAST];
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hs_s3 <= hs_nxt;
			hs_s4 <= hs_s3;
			ls_s4 <= hs_s3.light * hs_s3.sat;
			hs_s5 <= hs_s4;
			q2_s5 <= q2;
			p2_s5 <= p2;
			hs_s6 <= hs_s5;
			q_s6 <= div_full(q2_s5);
			p_s6 <= div_full(p2_s5);
			rp_r_s6 <= ramp_place(wrap_pos(t6 + TWO_TURN));
			rp_g_s6 <= ramp_place(t6[B+2:0]);
			rp_b_s6 <= ramp_place(wrap_pos(t6 + FOUR_TURN));
			hs_s7 <= hs_s6;
			q_s7 <= q_s6;
			p_s7 <= p_s6;
			sel_r_s7 <= rp_r_s6.sel;
			sel_g_s7 <= rp_g_s6.sel;
			sel_b_s7 <= rp_b_s6.sel;
			prod_r_s7 <= diff * rp_r_s6.frac;
			prod_g_s7 <= diff * rp_g_s6.frac;
			prod_b_s7 <= diff * rp_b_s6.frac;
			result_s8 <= res_nxt;
		end
	end

	assign result_valid = valid_s8;
	assign result = result_s8;

endmodule

/* hw/rtl/rgb_hsl_convert_adjust_unit.sv */
// Top level of the RGB/HSL conversion and lightness adjustment unit.
// Instantiates rhca_front, rhca_queue and rhca_back; depends on rhca_pkg.
//
// Input channel pixel/pixel_valid/pixel_stall carries one pixel beat: an
// operation code (RGB to HSL, HSL to RGB, darken, lighten), three colour
// values, alpha and a lightness step. Output channel result/result_valid/
// result_stall carries one result beat per pixel beat, in the same order.
// A beat moves at a rising edge with valid high and stall low.
// From acceptance to result_valid a beat passes one front stage, one
// queue slot, 17 divider steps (one quotient bit each for saturation and
// hue) and six conversion stages. One beat per cycle unless stalled.
// Reset clears every valid bit and empties the queue; payload registers
// are not reset. While result_stall holds a waiting result, the back end
// freezes, the four-entry queue fills and pixel_stall then rises.
`timescale 1ns / 1ps

module rgb_hsl_convert_adjust_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  rhca_pkg::pixel_t  pixel,
	input  logic              pixel_valid,
	output logic              pixel_stall,
	output rhca_pkg::result_t result,
	output logic              result_valid,
	input  logic              result_stall
);
	import rhca_pkg::*;

	work_t work, head;
	logic  work_valid, work_full, empty, pop;

	rhca_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pixel),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.work       (work),
		.work_valid (work_valid),
		.work_full  (work_full)
	);

	rhca_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_data(work),
		.push     (work_valid),
		.full     (work_full),
		.head     (head),
		.pop      (pop),
		.empty    (empty)
	);

	rhca_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

/* tb/rgb_hsl_convert_adjust_unit_tb.sv */
// Self-checking testbench for the RGB/HSL conversion and lightness adjustment unit.
// A scoreboard class predicts each result from the accepted pixel and checks in order.
// Depends on rhca_pkg and rgb_hsl_convert_adjust_unit.
`timescale 1ns / 1ps

module rgb_hsl_convert_adjust_unit_tb;
	import rhca_pkg::*;

	localparam longint FULL = (64'd1 << CHANNEL_BITS) - 1;
	localparam longint TURN = 64'd1 << CHANNEL_BITS;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	class colour_scoreboard;
		result_t pending[$];
		int mismatches;

		function void to_hsl(longint r, longint g, longint b,
				output longint h, output longint s, output longint l);
			longint mx, mn, sum, d, den, num;
			mx = r; mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			sum = mx + mn;
			l = (sum + 1) >> 1;
			h = 0; s = 0;
			if (mx != mn) begin
				d = mx - mn;
				den = (sum > FULL) ? (2 * FULL - sum) : sum;
				s = (FULL * d + den / 2) / den;
				if (mx == r)
					num = (g >= b) ? (g - b) : (6 * d - (b - g));
				else if (mx == g)
					num = 2 * d + b - r;
				else
					num = 4 * d + r - g;
				h = (((num << CHANNEL_BITS) + 3 * d) / (6 * d)) & FULL;
			end
		endfunction

		function longint ramp(longint p, longint q, longint t);
			longint f;
			if (t < TURN)
				f = t;
			else if (t < 3 * TURN)
				return q;
			else if (t < 4 * TURN)
				f = 4 * TURN - t;
			else
				return p;
			return (p * TURN + (q - p) * f + (TURN >> 1)) >> CHANNEL_BITS;
		endfunction

		function longint wrap_turn(longint t);
			return (t >= 6 * TURN) ? t - 6 * TURN : t;
		endfunction

		function void to_rgb(longint h, longint s, longint l,
				output longint r, output longint g, output longint b);
			longint q2, p2, q, p, t;
			if (s == 0) begin
				r = l; g = l; b = l;
			end else begin
				if (2 * l < FULL)
					q2 = l * (FULL + s);
				else
					q2 = l * FULL + s * FULL - l * s;
				p2 = 2 * l * FULL - q2;
				q = (q2 + FULL / 2) / FULL;
				p = (p2 + FULL / 2) / FULL;
				t = 6 * h;
				r = ramp(p, q, wrap_turn(t + 2 * TURN));
				g = ramp(p, q, t);
				b = ramp(p, q, wrap_turn(t + 4 * TURN));
			end
		endfunction

		function void note_pixel(pixel_t px);
			longint a, b, c, amt, h, s, l, x, y, z;
			result_t res;
			a = px.red_or_hue; b = px.green_or_sat; c = px.blue_or_light;
			amt = px.adjust_amount;
			case (px.operation)
				OP_TO_HSL: to_hsl(a, b, c, x, y, z);
				OP_TO_RGB: to_rgb(a, b, c, x, y, z);
				default: begin
					to_hsl(a, b, c, h, s, l);
					if (px.operation == OP_DARKEN)
						l = (l > amt) ? l - amt : 0;
					else
						l = (l + amt > FULL) ? FULL : l + amt;
					to_rgb(h, s, l, x, y, z);
				end
			endcase
			res.out_red_or_hue = chan_t'(x);
			res.out_green_or_sat = chan_t'(y);
			res.out_blue_or_light = chan_t'(z);
			res.alpha_out = px.alpha_in;
			pending.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result beat %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.out_red_or_hue !== want.out_red_or_hue
					|| got.out_green_or_sat !== want.out_green_or_sat
					|| got.out_blue_or_light !== want.out_blue_or_light
					|| got.alpha_out !== want.alpha_out) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch: expected %h %h %h %h, got %h %h %h %h",
						want.out_red_or_hue, want.out_green_or_sat,
						want.out_blue_or_light, want.alpha_out,
						got.out_red_or_hue, got.out_green_or_sat,
						got.out_blue_or_light, got.alpha_out);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	pixel_t pixel;
	logic pixel_valid;
	logic pixel_stall;
	result_t result;
	logic result_valid;
	logic result_stall;

	colour_scoreboard board;
	int idle_pct;
	int quiet_cycles;
	bit sending_done;

	rgb_hsl_convert_adjust_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.result(result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function chan_t edgy_chan();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CH_FULL;
			2: return chan_t'($urandom_range(0, 3));
			3: return CH_FULL - chan_t'($urandom_range(0, 3));
			default: return chan_t'($urandom);
		endcase
	endfunction

	task automatic send_pixel(pixel_t px);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			pixel_valid <= 1'b0;
			@(negedge clk);
		end
		pixel <= px;
		pixel_valid <= 1'b1;
		do
			@(posedge clk);
		while (pixel_stall);
		@(negedge clk);
	endtask

	task automatic send_colour(op_code_t op, chan_t a, chan_t b, chan_t c, chan_t amt);
		pixel_t px;
		px.operation = op;
		px.red_or_hue = a;
		px.green_or_sat = b;
		px.blue_or_light = c;
		px.alpha_in = chan_t'($urandom);
		px.adjust_amount = amt;
		send_pixel(px);
	endtask

	always @(posedge clk) begin
		if (pixel_valid && !pixel_stall)
			board.note_pixel(pixel);
		if (result_valid && !result_stall)
			board.check_result(result);
	end

	always @(negedge clk)
		result_stall <= arst_n && idle_pct > 0 && ($urandom_range(0, 99) < idle_pct);

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else if (arst_n && !(sending_done && board.pending.size() == 0))
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		pixel_t px;
		board = new();
		idle_pct = 21;
		quiet_cycles = 0;
		sending_done = 0;
		pixel = '0;
		pixel_valid = 1'b0;
		result_stall = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: every operation, grey, zero saturation and the extremes.
		send_colour(OP_TO_HSL, '0, '0, '0, '0);
		send_colour(OP_TO_HSL, CH_FULL, CH_FULL, CH_FULL, '0);
		send_colour(OP_TO_HSL, CH_FULL, '0, '0, '0);
		send_colour(OP_TO_HSL, '0, CH_FULL, '0, '0);
		send_colour(OP_TO_HSL, '0, '0, CH_FULL, '0);
		send_colour(OP_TO_HSL, CH_FULL, CH_FULL, '0, '0);
		send_colour(OP_TO_HSL, CH_FULL, '0, CH_FULL, '0);
		send_colour(OP_TO_HSL, CH_FULL, 16'd1, 16'd2, '0);
		send_colour(OP_TO_RGB, 16'h1234, '0, 16'h8000, '0);
		send_colour(OP_TO_RGB, '0, CH_FULL, 16'h7fff, '0);
		send_colour(OP_TO_RGB, CH_FULL, CH_FULL, CH_FULL, '0);
		send_colour(OP_TO_RGB, 16'h5555, CH_FULL, 16'h8000, '0);
		send_colour(OP_TO_RGB, 16'haaab, 16'h8000, 16'h4000, '0);
		send_colour(OP_TO_RGB, 16'hffff, 16'h0001, 16'h0001, '0);
		send_colour(OP_DARKEN, CH_FULL, 16'h4000, '0, CH_FULL);
		send_colour(OP_DARKEN, 16'h8000, 16'h8000, 16'h8000, 16'h1000);
		send_colour(OP_DARKEN, 16'h3000, 16'h9000, 16'hc000, '0);
		send_colour(OP_LIGHTEN, '0, 16'h4000, CH_FULL, CH_FULL);
		send_colour(OP_LIGHTEN, 16'h1000, 16'h1000, 16'h1000, 16'h2000);
		send_colour(OP_LIGHTEN, 16'hc000, 16'h2000, 16'h7000, 16'h0400);
		px = '1;
		send_pixel(px);
		pixel_valid <= 1'b0;

		// The sender waits here until every expected beat has come back.
		while (board.pending.size() != 0)
			@(negedge clk);

		for (int i = 0; i < 600; i++) begin
			idle_pct = (i >= 200 && i < 320) ? 0 : 21;
			px.operation = op_code_t'($urandom_range(0, 3));
			px.red_or_hue = edgy_chan();
			px.green_or_sat = edgy_chan();
			px.blue_or_light = edgy_chan();
			px.alpha_in = chan_t'($urandom);
			px.adjust_amount = ($urandom_range(0, 3) == 0) ? edgy_chan()
				: chan_t'($urandom_range(0, 16'h3fff));
			send_pixel(px);
		end
		pixel_valid <= 1'b0;
		sending_done = 1;

		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (board.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/rhca_pkg.sv
hw/rtl/rhca_front.sv
hw/rtl/rhca_queue.sv
hw/rtl/rhca_back.sv
hw/rtl/rgb_hsl_convert_adjust_unit.sv
tb/rgb_hsl_convert_adjust_unit_tb.sv
